[sv/mpst_pkg.sv]
// Package with payload types and fixed-point constants for the max product subarray tracker.
package mpst_pkg;

   localparam int SAMPLE_W = 32;
   localparam int PROD_W   = 64;
   localparam int INDEX_W  = 16;
   localparam int Q_FRAC   = 16;

   localparam logic signed [PROD_W-1:0] PROD_MAX = {1'b0, {(PROD_W-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] PROD_MIN = {1'b1, {(PROD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       is_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] best_product;
      logic [INDEX_W-1:0]       low_index;
      logic [INDEX_W-1:0]       high_index;
   } rsp_payload_type;

endpackage

[sv/mpst_stream_if.sv]
// Valid/ready stream interface that carries one payload per transaction.
interface mpst_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[sv/mpst_mul_q.sv]
// Saturating Q32.32 by Q16.16 multiply with floor rounding back to Q32.32.
module mpst_mul_q (
   input  logic signed [mpst_pkg::PROD_W-1:0]   run_value,
   input  logic signed [mpst_pkg::SAMPLE_W-1:0] sample,
   output logic signed [mpst_pkg::PROD_W-1:0]   product
);

   logic                              neg;
   logic [mpst_pkg::PROD_W-1:0]       a_mag;
   logic [mpst_pkg::SAMPLE_W-1:0]     b_mag;
   logic [mpst_pkg::PROD_W-1:0]       part_lo;
   logic [mpst_pkg::PROD_W-1:0]       part_hi;
   logic [mpst_pkg::PROD_W-1:0]       q;
   logic [mpst_pkg::PROD_W-1:0]       q_neg;

   // The magnitude product is split into two 32 by 32 partial products.
   always_comb begin
      neg     = run_value[mpst_pkg::PROD_W-1] ^ sample[mpst_pkg::SAMPLE_W-1];
      a_mag   = run_value[mpst_pkg::PROD_W-1] ? 64'(-run_value) : 64'(run_value);
      b_mag   = sample[mpst_pkg::SAMPLE_W-1] ? 32'(-sample) : 32'(sample);
      part_lo = a_mag[31:0] * b_mag;
      part_hi = a_mag[63:32] * b_mag;
      q       = {part_hi[47:0], 16'b0} + {16'b0, part_lo[63:16]};
      q_neg   = q + 64'(part_lo[15:0] != 16'b0);
      priority if (part_hi[63:47] != 17'b0) begin
         product = neg ? mpst_pkg::PROD_MIN : mpst_pkg::PROD_MAX;
      end else if (!neg) begin
         product = q[63] ? mpst_pkg::PROD_MAX : $signed(q);
      end else begin
         product = q_neg[63] ? mpst_pkg::PROD_MIN : $signed(-q_neg);
      end
   end

endmodule

[sv/max_product_subarray_tracker_top.sv]
// Top level of the max product subarray tracker: input register, update logic, result register.
//
//   Channel | Dir | Payload                                   | Transaction
//   req_if  | in  | sample (Q16.16), is_last                  | one sample
//   rsp_if  | out | best_product (Q32.32), low_index, high_idx| one result per sequence
//
// A sample is registered on acceptance and folded into the running state from the
// input register; one sample is taken every cycle unless a final sample waits there
// behind a pending result. The run registers loop back through two saturating
// multipliers and their compares, no register between. The result register holds
// one result; a final sample that arrives while it is pending waits in the input
// register, stalling the input while that result is held and as it is taken.
// Reset is synchronous and clears the control state; run values need none.
module max_product_subarray_tracker_top #(
   parameter int MAX_LENGTH = 65536
) (
   input  logic          clock,
   input  logic          reset,
   mpst_stream_if.sink   req_if,
   mpst_stream_if.source rsp_if
);

   localparam int IDX_W = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
   localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(MAX_LENGTH - 1);

   logic                                  in_valid_ff, in_valid_in;
   mpst_pkg::req_payload_type             in_data_ff;
   logic                                  rsp_valid_ff, rsp_valid_in;
   mpst_pkg::rsp_payload_type             rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]                      pos_ff, pos_in;
   logic signed [mpst_pkg::PROD_W-1:0]    run_max_ff, run_max_in;
   logic signed [mpst_pkg::PROD_W-1:0]    run_min_ff, run_min_in;
   logic [IDX_W-1:0]                      max_start_ff, max_start_in;
   logic [IDX_W-1:0]                      min_start_ff, min_start_in;
   logic signed [mpst_pkg::PROD_W-1:0]    best_ff, best_in;
   logic [IDX_W-1:0]                      best_low_ff, best_low_in;
   logic [IDX_W-1:0]                      best_high_ff, best_high_in;

   logic                                  accept;
   logic                                  advance;
   logic                                  positive;
   logic signed [mpst_pkg::PROD_W-1:0]    wide;
   logic signed [mpst_pkg::PROD_W-1:0]    src_max, src_min;
   logic signed [mpst_pkg::PROD_W-1:0]    prod_max, prod_min;
   logic [IDX_W-1:0]                      start_max, start_min;

   assign advance = in_valid_ff && (!in_data_ff.is_last || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || !in_data_ff.is_last || !rsp_valid_ff;
   assign accept = req_if.valid && req_if.ready;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   assign positive = !in_data_ff.sample[mpst_pkg::SAMPLE_W-1] && (in_data_ff.sample != '0);
   assign wide     = {{(mpst_pkg::PROD_W - mpst_pkg::SAMPLE_W - mpst_pkg::Q_FRAC)
                        {in_data_ff.sample[mpst_pkg::SAMPLE_W-1]}},
                      in_data_ff.sample, {mpst_pkg::Q_FRAC{1'b0}}};

   // A nonpositive sample swaps which run feeds the new largest and smallest.
   assign src_max   = positive ? run_max_ff : run_min_ff;
   assign src_min   = positive ? run_min_ff : run_max_ff;
   assign start_max = positive ? max_start_ff : min_start_ff;
   assign start_min = positive ? min_start_ff : max_start_ff;

   mpst_mul_q u_mul_max (
      .run_value (src_max),
      .sample    (in_data_ff.sample),
      .product   (prod_max)
   );

   mpst_mul_q u_mul_min (
      .run_value (src_min),
      .sample    (in_data_ff.sample),
      .product   (prod_min)
   );

   always_comb begin
      run_max_in   = run_max_ff;
      run_min_in   = run_min_ff;
      max_start_in = max_start_ff;
      min_start_in = min_start_ff;
      best_in      = best_ff;
      best_low_in  = best_low_ff;
      best_high_in = best_high_ff;
      pos_in       = pos_ff;
      if (advance) begin
         if (pos_ff == '0) begin
            run_max_in   = wide;
            run_min_in   = wide;
            max_start_in = '0;
            min_start_in = '0;
            best_in      = wide;
            best_low_in  = '0;
            best_high_in = '0;
         end else begin
            if (wide >= prod_max) begin
               run_max_in   = wide;
               max_start_in = pos_ff;
            end else begin
               run_max_in   = prod_max;
               max_start_in = start_max;
            end
            if (wide <= prod_min) begin
               run_min_in   = wide;
               min_start_in = pos_ff;
            end else begin
               run_min_in   = prod_min;
               min_start_in = start_min;
            end
            if (run_max_in >= best_ff) begin
               best_in      = run_max_in;
               best_low_in  = max_start_in;
               best_high_in = pos_ff;
            end
         end
         if (in_data_ff.is_last) begin
            pos_in = '0;
         end else if (pos_ff != POS_LAST) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_data_in.best_product = best_in;
      rsp_data_in.low_index    = mpst_pkg::INDEX_W'(best_low_in);
      rsp_data_in.high_index   = mpst_pkg::INDEX_W'(best_high_in);
      rsp_valid_in             = rsp_valid_ff && !rsp_if.ready;
      if (advance && in_data_ff.is_last) begin
         rsp_valid_in = 1'b1;
      end
      in_valid_in = in_valid_ff && !advance;
      if (accept) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_if.payload;
      end
      if (advance && in_data_ff.is_last) begin
         rsp_data_ff <= rsp_data_in;
      end
      run_max_ff   <= run_max_in;
      run_min_ff   <= run_min_in;
      max_start_ff <= max_start_in;
      min_start_ff <= min_start_in;
      best_ff      <= best_in;
      best_low_ff  <= best_low_in;
      best_high_ff <= best_high_in;
   end

   // A final sample always leaves the tracker ready for a new sequence.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.is_last |=> pos_ff == '0)
      else $error("position not cleared after final sample");

   // A result only appears when a final sample has been folded in.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_data_ff.is_last))
      else $error("result raised without a final sample");

   // A non-final sample never leaves the position at the start of a sequence.
   assert property (@(posedge clock) disable iff (reset)
      advance && !in_data_ff.is_last |=> pos_ff != '0)
      else $error("position returned to zero mid-sequence");

   // A pending result is never overwritten while a final sample waits behind it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready && in_valid_ff && in_data_ff.is_last |-> !advance)
      else $error("pending result overwritten");

endmodule

[dv/tb_max_product_subarray_tracker_top.sv]
// Self-checking testbench for the max product subarray tracker with a built-in predictor.
module tb_max_product_subarray_tracker_top;

   localparam int MAX_LEN    = 65536;
   localparam int LONG_LEN   = 160;
   localparam int RANDOM_LEN = 1550;
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN_WAIT = 16;

   localparam logic signed [127:0] WIDE_MAX = mpst_pkg::PROD_MAX;
   localparam logic signed [127:0] WIDE_MIN = mpst_pkg::PROD_MIN;

   typedef struct packed {
      logic signed [mpst_pkg::SAMPLE_W-1:0] sample;
      logic                                 is_last;
      logic                                 typed;
      mpst_pkg::rsp_payload_type            best;
   } sample_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mpst_stream_if #(.payload_type(mpst_pkg::req_payload_type)) req_if ();
   mpst_stream_if #(.payload_type(mpst_pkg::rsp_payload_type)) rsp_if ();

   max_product_subarray_tracker_top #(
      .MAX_LENGTH(MAX_LEN)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic signed [mpst_pkg::PROD_W-1:0] trk_largest;
   logic signed [mpst_pkg::PROD_W-1:0] trk_smallest;
   logic signed [mpst_pkg::PROD_W-1:0] trk_best;
   logic [mpst_pkg::INDEX_W-1:0]       trk_largest_start;
   logic [mpst_pkg::INDEX_W-1:0]       trk_smallest_start;
   logic [mpst_pkg::INDEX_W-1:0]       trk_best_low;
   logic [mpst_pkg::INDEX_W-1:0]       trk_best_high;
   logic [mpst_pkg::INDEX_W-1:0]       trk_position;

   mpst_pkg::rsp_payload_type expected_best_q [$];
   int errors        = 0;
   int hold_requests = 0;
   int burst_left    = 1;
   int gap_max       = 6;

   sample_row_type directed_rows [24] = '{
      '{32'sh7FFF_FFFF, 1'b1, 1'b1, '{64'sh0000_7FFF_FFFF_0000, 16'd0, 16'd0}},
      '{32'sh8000_0000, 1'b1, 1'b1, '{64'shFFFF_8000_0000_0000, 16'd0, 16'd0}},
      '{32'sh0000_0000, 1'b1, 1'b1, '{64'sh0, 16'd0, 16'd0}},
      '{32'sh0001_0000, 1'b0, 1'b0, '0},
      '{32'sh0002_0000, 1'b0, 1'b0, '0},
      '{32'shFFFF_0000, 1'b0, 1'b0, '0},
      '{32'shFFFE_0000, 1'b1, 1'b0, '0},
      '{32'sh7FFF_FFFF, 1'b0, 1'b0, '0},
      '{32'sh7FFF_FFFF, 1'b0, 1'b0, '0},
      '{32'sh7FFF_FFFF, 1'b1, 1'b0, '0},
      '{32'sh8000_0000, 1'b0, 1'b0, '0},
      '{32'sh7FFF_FFFF, 1'b1, 1'b0, '0},
      '{32'sh8000_0000, 1'b0, 1'b0, '0},
      '{32'sh8000_0000, 1'b0, 1'b0, '0},
      '{32'sh8000_0000, 1'b1, 1'b0, '0},
      '{32'sh0001_0000, 1'b0, 1'b0, '0},
      '{32'sh0001_0000, 1'b0, 1'b0, '0},
      '{32'sh0001_0000, 1'b1, 1'b0, '0},
      '{32'sh0005_0000, 1'b0, 1'b0, '0},
      '{32'sh0000_0000, 1'b0, 1'b0, '0},
      '{32'shFFFF_0000, 1'b1, 1'b0, '0},
      '{32'sh0000_0001, 1'b0, 1'b0, '0},
      '{32'sh0000_0001, 1'b0, 1'b0, '0},
      '{32'shFFFF_8001, 1'b1, 1'b0, '0}
   };

   function automatic logic signed [mpst_pkg::PROD_W-1:0] scale_product(
      input logic signed [mpst_pkg::PROD_W-1:0]   run,
      input logic signed [mpst_pkg::SAMPLE_W-1:0] s
   );
      logic signed [127:0] full;
      logic signed [127:0] shifted;
      full    = run * s;
      shifted = full >>> mpst_pkg::Q_FRAC;
      if (shifted > WIDE_MAX) begin
         return mpst_pkg::PROD_MAX;
      end
      if (shifted < WIDE_MIN) begin
         return mpst_pkg::PROD_MIN;
      end
      return shifted[mpst_pkg::PROD_W-1:0];
   endfunction

   function automatic void clear_tracker();
      trk_largest        = '0;
      trk_smallest       = '0;
      trk_best           = '0;
      trk_largest_start  = '0;
      trk_smallest_start = '0;
      trk_best_low       = '0;
      trk_best_high      = '0;
      trk_position       = '0;
   endfunction

   function automatic bit track_sample(input mpst_pkg::req_payload_type item,
                                       output mpst_pkg::rsp_payload_type best);
      logic signed [mpst_pkg::PROD_W-1:0] widened;
      logic signed [mpst_pkg::PROD_W-1:0] ext_max;
      logic signed [mpst_pkg::PROD_W-1:0] ext_min;
      logic [mpst_pkg::INDEX_W-1:0]       from_max;
      logic [mpst_pkg::INDEX_W-1:0]       from_min;
      logic [mpst_pkg::INDEX_W-1:0]       idx;
      idx     = trk_position;
      widened = $signed({{(mpst_pkg::PROD_W-mpst_pkg::SAMPLE_W-mpst_pkg::Q_FRAC)
                          {item.sample[mpst_pkg::SAMPLE_W-1]}}, item.sample,
                         {mpst_pkg::Q_FRAC{1'b0}}});
      best    = '0;
      if (idx == '0) begin
         trk_largest        = widened;
         trk_smallest       = widened;
         trk_best           = widened;
         trk_largest_start  = '0;
         trk_smallest_start = '0;
         trk_best_low       = '0;
         trk_best_high      = '0;
      end else begin
         if (item.sample > 0) begin
            ext_max  = scale_product(trk_largest, item.sample);
            from_max = trk_largest_start;
            ext_min  = scale_product(trk_smallest, item.sample);
            from_min = trk_smallest_start;
         end else begin
            ext_max  = scale_product(trk_smallest, item.sample);
            from_max = trk_smallest_start;
            ext_min  = scale_product(trk_largest, item.sample);
            from_min = trk_largest_start;
         end
         if (widened >= ext_max) begin
            trk_largest       = widened;
            trk_largest_start = idx;
         end else begin
            trk_largest       = ext_max;
            trk_largest_start = from_max;
         end
         if (widened <= ext_min) begin
            trk_smallest       = widened;
            trk_smallest_start = idx;
         end else begin
            trk_smallest       = ext_min;
            trk_smallest_start = from_min;
         end
         if (trk_largest >= trk_best) begin
            trk_best      = trk_largest;
            trk_best_low  = trk_largest_start;
            trk_best_high = idx;
         end
      end
      if (item.is_last) begin
         best.best_product = trk_best;
         best.low_index    = trk_best_low;
         best.high_index   = trk_best_high;
         clear_tracker();
         return 1'b1;
      end
      if (int'(idx) < MAX_LEN - 1) begin
         trk_position = idx + 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic signed [mpst_pkg::SAMPLE_W-1:0] pick_sample();
      logic signed [mpst_pkg::SAMPLE_W-1:0] mag;
      case ($urandom_range(9))
         0, 1: begin
            return $urandom;
         end
         2, 3, 4: begin
            mag = $urandom_range(32'h0002_8000, 32'h0000_4000);
            return $urandom_range(1) ? -mag : mag;
         end
         5: begin
            return '0;
         end
         6: begin
            case ($urandom_range(5))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 32'sh0000_0001;
               3: return 32'shFFFF_FFFF;
               4: return 32'sh0001_0000;
               default: return 32'shFFFF_0000;
            endcase
         end
         7: begin
            mag = $urandom_range(255);
            return $urandom_range(1) ? -mag : mag;
         end
         default: begin
            mag = $urandom_range(7);
            return (mag - 3) <<< mpst_pkg::Q_FRAC;
         end
      endcase
   endfunction

   task automatic drive_sample(
      input logic signed [mpst_pkg::SAMPLE_W-1:0] s,
      input logic                                 last,
      input bit                                   use_typed,
      input mpst_pkg::rsp_payload_type            typed
   );
      mpst_pkg::req_payload_type item;
      mpst_pkg::rsp_payload_type best;
      int                        gap;
      item.sample  = s;
      item.is_last = last;
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (track_sample(item, best)) begin
         expected_best_q.push_back(use_typed ? typed : best);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(120, 40) : $urandom_range(12, 1);
         gap = $urandom_range(gap_max, 1);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_best_q.size() != 0);
   endtask

   task automatic check_best(input mpst_pkg::rsp_payload_type got);
      mpst_pkg::rsp_payload_type want;
      if (expected_best_q.size() == 0) begin
         $error("best_product: expected nothing, got %0d", $signed(got.best_product));
         errors++;
         return;
      end
      want = expected_best_q.pop_front();
      if (got.best_product !== want.best_product) begin
         $error("best_product: expected %0d, got %0d", $signed(want.best_product),
                $signed(got.best_product));
         errors++;
      end
      if (got.low_index !== want.low_index) begin
         $error("low_index: expected %0d, got %0d", want.low_index, got.low_index);
         errors++;
      end
      if (got.high_index !== want.high_index) begin
         $error("high_index: expected %0d, got %0d", want.high_index, got.high_index);
         errors++;
      end
   endtask

   initial begin : receiver
      int rx_cycle;
      int rx_mode;
      int rx_mode_left;
      int hold_left;
      int holds_served;
      rx_cycle     = 0;
      rx_mode      = 0;
      rx_mode_left = 0;
      hold_left    = 0;
      holds_served = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            check_best(rsp_if.payload);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_LEN;
            rsp_if.ready <= 1'b0;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode      = $urandom_range(3);
               rx_mode_left = $urandom_range(256, 32);
            end
            rx_mode_left--;
            case (rx_mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(9) < 7);
               2: rsp_if.ready <= (rx_cycle % 5 != 0);
               default: rsp_if.ready <= ($urandom_range(3) == 0);
            endcase
         end
      end
   end

   initial begin : sender
      int  sent;
      int  len;
      bit  held;
      bit  paused;
      bit  long_done;
      sent      = 0;
      held      = 1'b0;
      paused    = 1'b0;
      long_done = 1'b0;
      clear_tracker();
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         drive_sample(directed_rows[i].sample, directed_rows[i].is_last,
                      directed_rows[i].typed, directed_rows[i].best);
      end
      drain_results();

      while (sent < RANDOM_LEN) begin
         if (!held && sent >= 300) begin
            hold_requests <= hold_requests + 1;
            held = 1'b1;
         end
         if (!paused && sent >= 800) begin
            drain_results();
            paused = 1'b1;
         end
         if (!long_done && sent >= 1000) begin
            gap_max = 2;
            for (int k = 0; k < LONG_LEN; k++) begin
               drive_sample(($urandom_range(15) == 0) ? pick_sample() : 32'sh0001_0000,
                            k == LONG_LEN - 1, 1'b0, '0);
            end
            gap_max   = 6;
            long_done = 1'b1;
            sent += LONG_LEN;
         end
         len = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
         for (int k = 0; k < len; k++) begin
            drive_sample(pick_sample(), k == len - 1, 1'b0, '0);
         end
         sent += len;
      end

      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
